@@ sv/sbus_frame_receiver_assert.svh @@
// assertion macros shared by the sbus frame receiver checker
`ifndef SBUS_FRAME_RECEIVER_ASSERT_SVH
`define SBUS_FRAME_RECEIVER_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define SBR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sbus frame receiver check failed");

// property that must hold in the cycle after a condition
`define SBR_ASSERT_NEXT(lbl, cond, prop) `SBR_ASSERT(lbl, (cond) |=> (prop))

`endif

@@ sv/sbr_pkg.sv @@
// shared types and constants of the sbus frame receiver
`timescale 1ns / 1ps
package sbr_pkg;

	localparam int FRAME_LEN = 25;
	localparam int NUM_CH    = 16;
	localparam int CH_W      = 11;
	localparam int IDX_W     = 4;
	localparam int ADDR_W    = 5;
	localparam int BUF_W     = 18;   // up to ten leftover bits plus one byte
	localparam int NBITS_W   = 5;

	localparam logic [ADDR_W-1:0] FIRST_DATA_POS = 5'd1;
	localparam logic [ADDR_W-1:0] FLAG_POS       = 5'd23;
	localparam logic [ADDR_W-1:0] END_POS        = 5'd24;
	localparam logic [IDX_W-1:0]  LAST_CH        = 4'd15;
	localparam logic [7:0]        IDLE_MAX       = 8'hFF;

	// configuration register indexes
	localparam logic [1:0] REG_START_BYTE    = 2'd0;
	localparam logic [1:0] REG_END_BYTE      = 2'd1;
	localparam logic [1:0] REG_GAP_TICKS     = 2'd2;
	localparam logic [1:0] REG_FAILSAFE_MASK = 2'd3;

	// reset values
	localparam logic [7:0] START_BYTE_RST    = 8'h0F;
	localparam logic [7:0] END_BYTE_RST      = 8'h00;
	localparam logic [7:0] GAP_TICKS_RST     = 8'd3;
	localparam logic [7:0] FAILSAFE_MASK_RST = 8'h0C;

	// input item kinds
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] gap_ticks;
		logic [7:0] failsafe_mask;
	} cfg_t;

	// handed from the assembler to the unpacker when a good frame is complete
	typedef struct packed {
		logic       go;
		logic [7:0] flags;
		logic       failsafe;
	} frame_t;

	typedef struct packed {
		logic [IDX_W-1:0] channel_index;
		logic [CH_W-1:0]  channel_value;
		logic [7:0]       flags;
		logic             failsafe;
		logic             last;
	} result_t;

endpackage

@@ sv/sbus_frame_receiver.sv @@
// top level of the sbus frame receiver
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser: cmd, tdata: rx_byte
//  m_*      out  m_tvalid/m_tready   tdata: index/value/flags/failsafe, tlast: last
//  cfg_*    in   cfg_we              cfg_index selects register, cfg_data value
//
// a byte or tick item is taken while no frame is waiting for or being unpacked
// the byte that closes a good frame starts the unpacker: 22 reads of the
// frame ram at one read port, each a read state then a shift state, and an
// output state for each channel that waits for m_tready, 16 results in all
// input stays stalled from the closing byte until the channel 15 item is taken
// reset is asynchronous; the frame ram is not cleared, a frame only reads bytes
// written in that same frame
`timescale 1ns / 1ps
module sbus_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// received items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // [0] cmd
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// channel results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] channel_index, [14:4] channel_value,
	                               // [22:15] flags, [23] failsafe
	output logic        m_tlast,   // last
	// register writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	sbr_pkg::cfg_t    cfg_q;
	sbr_pkg::frame_t  frame;
	sbr_pkg::result_t result;

	logic                       unp_busy;
	logic                       ram_we;
	logic [sbr_pkg::ADDR_W-1:0] ram_waddr;
	logic [7:0]                 ram_wdata;
	logic                       ram_re;
	logic [sbr_pkg::ADDR_W-1:0] ram_raddr;
	logic [7:0]                 ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte    <= sbr_pkg::START_BYTE_RST;
			cfg_q.end_byte      <= sbr_pkg::END_BYTE_RST;
			cfg_q.gap_ticks     <= sbr_pkg::GAP_TICKS_RST;
			cfg_q.failsafe_mask <= sbr_pkg::FAILSAFE_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbr_pkg::REG_START_BYTE:    cfg_q.start_byte    <= cfg_data;
				sbr_pkg::REG_END_BYTE:      cfg_q.end_byte      <= cfg_data;
				sbr_pkg::REG_GAP_TICKS:     cfg_q.gap_ticks     <= cfg_data;
				sbr_pkg::REG_FAILSAFE_MASK: cfg_q.failsafe_mask <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// byte/tick intake, writes bytes into the frame ram
	sbr_assembler u_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg       (cfg_q),
		.unp_busy  (unp_busy),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.frame     (frame)
	);

	// one 8-bit entry per frame position
	sbr_ram #(
		.WIDTH (8),
		.DEPTH (sbr_pkg::FRAME_LEN)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// walks the stored channel bytes and emits one item per channel
	sbr_unpacker u_unp (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.busy      (unp_busy),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.result    (result)
	);

	// pack the result item, first field lowest
	assign m_tdata = {result.failsafe, result.flags, result.channel_value,
		result.channel_index};
	assign m_tlast = result.last;

endmodule

@@ sv/sbr_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module sbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/sbr_assembler.sv @@
// byte and tick handling, frame storage writes and frame check
`timescale 1ns / 1ps
module sbr_assembler (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic                      s_tuser,
	input  logic [7:0]                s_tdata,
	input  sbr_pkg::cfg_t             cfg,
	input  logic                      unp_busy,
	output logic                      ram_we,
	output logic [sbr_pkg::ADDR_W-1:0] ram_waddr,
	output logic [7:0]                ram_wdata,
	output sbr_pkg::frame_t           frame
);

	logic [sbr_pkg::ADDR_W-1:0] cnt_q;
	logic [7:0]                 idle_q;
	logic [7:0]                 byte0_q;
	logic [7:0]                 flags_q;
	sbr_pkg::frame_t            frame_q;

	logic                       acc;
	logic                       is_byte;
	logic [sbr_pkg::ADDR_W-1:0] cnt_eff;
	logic                       store;
	logic                       complete;
	logic                       frame_ok;

	assign s_tready = !unp_busy && !frame_q.go;
	assign acc      = s_tvalid && s_tready;
	assign is_byte  = (s_tuser == sbr_pkg::CMD_BYTE);

	always_comb begin
		// a long gap drops any partial frame
		if (cnt_q != '0 && idle_q > cfg.gap_ticks) begin
			cnt_eff = '0;
		end else begin
			cnt_eff = cnt_q;
		end
		store    = acc && is_byte && (cnt_eff != '0 || s_tdata == cfg.start_byte);
		complete = store && (cnt_eff == sbr_pkg::END_POS);
		// closing byte of a frame with the right start and end bytes
		frame_ok = complete && byte0_q == cfg.start_byte && s_tdata == cfg.end_byte;
	end

	assign ram_we    = store;
	assign ram_waddr = cnt_eff;
	assign ram_wdata = s_tdata;
	assign frame     = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			idle_q   <= '0;
			frame_q  <= '0;
		end else begin
			frame_q.go <= frame_ok;
			if (acc) begin
				if (!is_byte) begin
					if (idle_q != sbr_pkg::IDLE_MAX) begin
						idle_q <= idle_q + 8'd1;
					end
				end else begin
					idle_q <= '0;
					if (!store || complete) begin
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_eff + sbr_pkg::ADDR_W'(1);
					end
					if (frame_ok) begin
						frame_q.flags    <= flags_q;
						frame_q.failsafe <= (flags_q & cfg.failsafe_mask) != 8'h00;
					end
				end
			end
		end
	end

	// copies of the start and flags bytes for the frame check
	always_ff @(posedge clk) begin
		if (store && cnt_eff == '0) begin
			byte0_q <= s_tdata;
		end
		if (store && cnt_eff == sbr_pkg::FLAG_POS) begin
			flags_q <= s_tdata;
		end
	end

endmodule

@@ sv/sbr_unpacker.sv @@
// reads a stored frame byte by byte and slices out the channel values
`timescale 1ns / 1ps
module sbr_unpacker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sbr_pkg::frame_t            frame,
	output logic                       busy,
	output logic                       ram_re,
	output logic [sbr_pkg::ADDR_W-1:0] ram_raddr,
	input  logic [7:0]                 ram_rdata,
	output logic                       m_valid,
	input  logic                       m_ready,
	output sbr_pkg::result_t           result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SHIFT,
		S_OUT
	} state_t;

	state_t                        state_q;
	logic [sbr_pkg::ADDR_W-1:0]    addr_q;
	logic [sbr_pkg::IDX_W-1:0]     ch_q;
	logic [sbr_pkg::BUF_W-1:0]     buf_q;
	logic [sbr_pkg::NBITS_W-1:0]   nbits_q;
	logic [sbr_pkg::CH_W-1:0]      value_q;
	logic [7:0]                    flags_q;
	logic                          fs_q;

	logic [sbr_pkg::BUF_W-1:0]     acc_buf;
	logic [sbr_pkg::NBITS_W-1:0]   acc_nbits;

	// append the new byte above the bits already held, lsb first
	always_comb begin
		acc_buf   = buf_q | ({{(sbr_pkg::BUF_W-8){1'b0}}, ram_rdata} << nbits_q);
		acc_nbits = nbits_q + sbr_pkg::NBITS_W'(8);
	end

	assign busy      = (state_q != S_IDLE);
	assign ram_re    = (state_q == S_READ);
	assign ram_raddr = addr_q;
	assign m_valid   = (state_q == S_OUT);

	assign result.channel_index = ch_q;
	assign result.channel_value = value_q;
	assign result.flags         = flags_q;
	assign result.failsafe      = fs_q;
	assign result.last          = (ch_q == sbr_pkg::LAST_CH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q  <= '0;
			ch_q    <= '0;
			buf_q   <= '0;
			nbits_q <= '0;
			value_q <= '0;
			flags_q <= '0;
			fs_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (frame.go) begin
						state_q <= S_READ;
						addr_q  <= sbr_pkg::FIRST_DATA_POS;
						ch_q    <= '0;
						buf_q   <= '0;
						nbits_q <= '0;
						flags_q <= frame.flags;
						fs_q    <= frame.failsafe;
					end
				end
				S_READ: begin
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					addr_q <= addr_q + sbr_pkg::ADDR_W'(1);
					if (acc_nbits >= sbr_pkg::NBITS_W'(sbr_pkg::CH_W)) begin
						value_q <= acc_buf[sbr_pkg::CH_W-1:0];
						buf_q   <= acc_buf >> sbr_pkg::CH_W;
						nbits_q <= acc_nbits - sbr_pkg::NBITS_W'(sbr_pkg::CH_W);
						state_q <= S_OUT;
					end else begin
						buf_q   <= acc_buf;
						nbits_q <= acc_nbits;
						state_q <= S_READ;
					end
				end
				S_OUT: begin
					if (m_ready) begin
						if (ch_q == sbr_pkg::LAST_CH) begin
							state_q <= S_IDLE;
						end else begin
							ch_q    <= ch_q + sbr_pkg::IDX_W'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/sbr_checker.sv @@
// port-level checks of the sbus frame receiver and their binding
`timescale 1ns / 1ps
`include "sbus_frame_receiver_assert.svh"
module sbr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// no item is taken while a channel result is on offer
	`SBR_ASSERT(a_no_intake_while_out, m_tvalid |-> !s_tready)

	// a result held back stays unchanged
	`SBR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// the frame ends on channel 15
	`SBR_ASSERT(a_last_is_ch15, m_tvalid && m_tlast |-> m_tdata[3:0] == 4'd15)

	// intake reopens right after the final channel of a frame
	`SBR_ASSERT_NEXT(a_reopen, m_tvalid && m_tready && m_tlast, s_tready)

	// a tick never gives a result in the next cycle
	`SBR_ASSERT_NEXT(a_tick_quiet, s_tvalid && s_tready && s_tuser, !m_tvalid)

endmodule

bind sbus_frame_receiver sbr_checker u_chk (.*);
